FILE: rtl/xml_markup_tokenizer_assert.svh
// Assertion macros shared by the tokenizer's checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef XML_MARKUP_TOKENIZER_ASSERT_SVH
`define XML_MARKUP_TOKENIZER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define XMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define XMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches reset itself.
`define XMT_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/xmt_pkg.sv
// Shared types and constants of the XML markup tokenizer.
// Depends on nothing; RTL users refer to it by scoped names.
`default_nettype none

package xmt_pkg;

  // Width of every offset field in a token record
  localparam int SPAN_W = 24;

  // Token record kinds
  typedef enum logic [2:0] {
    TK_TEXT      = 3'd0,
    TK_OPEN      = 3'd1,
    TK_CLOSE     = 3'd2,
    TK_CDATA     = 3'd3,
    TK_COMMENT   = 3'd4,
    TK_DECL      = 3'd5,
    TK_ATTR      = 3'd6,
    TK_MALFORMED = 3'd7
  } token_kind_t;

  // One result record
  typedef struct packed {
    token_kind_t       kind;
    logic [SPAN_W-1:0] span_begin;
    logic [SPAN_W-1:0] span_end;
    logic [SPAN_W-1:0] value_begin;
    logic [SPAN_W-1:0] value_end;
    logic              self_closing;
  } token_t;

  // Byte codes the scanner reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // Bytes skipped after "<![" before CDATA content is looked at
  localparam int CDATA_SKIP = 6;
  // Offset of CDATA content from the '!' and of comment text from the '!'
  localparam int CDATA_LEAD   = 8;
  localparam int COMMENT_LEAD = 3;
  // Bytes trimmed before the closing '>' of CDATA and comments
  localparam int TAIL_TRIM = 2;

endpackage

`default_nettype wire

FILE: rtl/xmt_if.sv
// Valid/ready channel interfaces of the tokenizer: byte input and token output.
// Depends on xmt_pkg for the record field widths.
`default_nettype none

interface xmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface xmt_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                token_kind;
  logic [xmt_pkg::SPAN_W-1:0] span_begin;
  logic [xmt_pkg::SPAN_W-1:0] span_end;
  logic [xmt_pkg::SPAN_W-1:0] value_begin;
  logic [xmt_pkg::SPAN_W-1:0] value_end;
  logic                      self_closing;

  modport source (output valid, output token_kind, output span_begin, output span_end,
                  output value_begin, output value_end, output self_closing,
                  input ready);
  modport sink   (input valid, input token_kind, input span_begin, input span_end,
                  input value_begin, input value_end, input self_closing,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/xmt_in_stage.sv
// Input register of the tokenizer: holds one byte beat until the scanner takes it.
// Depends on nothing beyond plain logic.
`default_nettype none

module xmt_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_final,
  input  wire logic       take_i,
  output logic            vld_o,
  output logic [7:0]      byte_o,
  output logic            fin_o
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       fin_r;

  // Accept a new beat when empty or when the held one leaves this cycle
  assign in_ready = !vld_r || take_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // Load the payload on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      fin_r  <= in_final;
    end
  end

  assign vld_o  = vld_r;
  assign byte_o = byte_r;
  assign fin_o  = fin_r;

endmodule

`default_nettype wire

FILE: rtl/xmt_scan.sv
// Tokenizer scan FSM: phase, byte offset, span marks, at most one record per byte.
// Depends on xmt_pkg for record type, kinds and byte codes.
`default_nettype none

module xmt_scan #(
  parameter int OFFSET_BITS = 24,
  parameter int NEST_LIMIT  = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       fin_i,
  output logic            emit_o,
  output xmt_pkg::token_t tok_o
);

  localparam int OB    = OFFSET_BITS;
  localparam int CNT_W = ($clog2(NEST_LIMIT + 1) > 3) ? $clog2(NEST_LIMIT + 1) : 3;
  localparam int SW    = xmt_pkg::SPAN_W;

  // Text flags: bit 2 all whitespace so far, bits 1..0 saturating length
  localparam logic [2:0] TF_RESET = 3'b100;

  typedef enum logic [14:0] {
    PH_TEXT    = 15'b000000000000001,
    PH_LT      = 15'b000000000000010,
    PH_CLOSE   = 15'b000000000000100,
    PH_DECL    = 15'b000000000001000,
    PH_BANG    = 15'b000000000010000,
    PH_CSKIP   = 15'b000000000100000,
    PH_CBODY   = 15'b000000001000000,
    PH_COMMENT = 15'b000000010000000,
    PH_NAME    = 15'b000000100000000,
    PH_GAP     = 15'b000001000000000,
    PH_ANAME   = 15'b000010000000000,
    PH_SEEKQ   = 15'b000100000000000,
    PH_VALUE   = 15'b001000000000000,
    PH_SLASH   = 15'b010000000000000,
    PH_DONE    = 15'b100000000000000
  } phase_t;

  phase_t          ph_r, ph_nxt;
  logic [OB-1:0]   pos_r, pos_nxt;
  logic [OB-1:0]   mf_r, mf_nxt;
  logic [OB-1:0]   ms_r, ms_nxt;
  logic [OB-1:0]   mt_r, mt_nxt;
  logic [OB-1:0]   m4_r, m4_nxt;
  logic [OB-1:0]   m5_r, m5_nxt;
  logic [7:0]      quote_r, quote_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]     prev_r, prev_nxt;
  logic [2:0]      tf_r, tf_nxt;
  logic            sf_r, sf_nxt;

  logic                 emit;
  xmt_pkg::token_kind_t kind;
  logic [OB-1:0]        sb, se, vb, ve;
  logic                 sc;

  logic [OB-1:0]    pos1;
  logic             is_ws;
  logic [1:0]       len;
  logic [OB-1:0]    nm_mf;
  logic [OB-1:0]    nm_end;
  logic [CNT_W-1:0] cnt_in;
  logic [CNT_W-1:0] cnt_dec;
  logic [OB-1:0]    cl_b, cl_e;

  // Widen or cut an offset to the record's field width
  function automatic logic [SW-1:0] to_fld(input logic [OB-1:0] x);
    logic [OB+SW-1:0] w;
    w = {{SW{1'b0}}, x};
    return w[SW-1:0];
  endfunction

  assign pos1  = pos_r + OB'(1);
  assign is_ws = (byte_i == xmt_pkg::CH_SP) || (byte_i == xmt_pkg::CH_TAB) ||
                 (byte_i == xmt_pkg::CH_LF) || (byte_i == xmt_pkg::CH_CR);

  // Work out the next state and the record caused by the held byte
  always_comb begin
    ph_nxt    = ph_r;
    pos_nxt   = pos_r;
    mf_nxt    = mf_r;
    ms_nxt    = ms_r;
    mt_nxt    = mt_r;
    m4_nxt    = m4_r;
    m5_nxt    = m5_r;
    quote_nxt = quote_r;
    cnt_nxt   = cnt_r;
    prev_nxt  = prev_r;
    tf_nxt    = tf_r;
    sf_nxt    = sf_r;
    emit      = 1'b0;
    kind      = xmt_pkg::TK_TEXT;
    sb        = '0;
    se        = '0;
    vb        = '0;
    ve        = '0;
    sc        = 1'b0;
    len       = tf_r[1:0];
    nm_mf     = (ph_r == PH_LT) ? pos_r : mf_r;
    nm_end    = pos_r;
    cnt_in    = (ph_r == PH_BANG) ? CNT_W'(1) : cnt_r;
    cnt_dec   = (cnt_in != '0) ? cnt_in - CNT_W'(1) : cnt_in;
    cl_b      = mf_r + ((ph_r == PH_CBODY) ? OB'(xmt_pkg::CDATA_LEAD)
                                           : OB'(xmt_pkg::COMMENT_LEAD));
    cl_e      = pos_r - OB'(xmt_pkg::TAIL_TRIM);
    if (cl_e < cl_b) begin
      cl_e = cl_b;
    end

    if (ph_r == PH_DONE) begin
      // Ignore everything until reset
    end else if (byte_i == xmt_pkg::CH_NUL) begin
      // End of document: report an unfinished construct
      if (ph_r != PH_TEXT) begin
        emit = 1'b1;
        kind = xmt_pkg::TK_MALFORMED;
        sb   = mf_r;
        se   = pos_r;
      end
      ph_nxt = PH_DONE;
    end else begin
      unique case (ph_r)
        PH_TEXT: begin
          if (byte_i == xmt_pkg::CH_LT) begin
            if (len != 2'd0 && !(len != 2'd3 && tf_r[2])) begin
              emit = 1'b1;
              kind = xmt_pkg::TK_TEXT;
              sb   = mf_r;
              se   = pos_r;
            end
            ph_nxt = PH_LT;
            mf_nxt = pos1;
          end else begin
            tf_nxt[1:0] = (len != 2'd3) ? len + 2'd1 : len;
            tf_nxt[2]   = tf_r[2] && is_ws;
          end
        end
        PH_LT, PH_NAME: begin
          if (ph_r == PH_LT && byte_i == xmt_pkg::CH_SLASH) begin
            ph_nxt = PH_CLOSE;
            mf_nxt = pos1;
          end else if (ph_r == PH_LT && byte_i == xmt_pkg::CH_QMARK) begin
            ph_nxt = PH_DECL;
            mf_nxt = pos_r;
          end else if (ph_r == PH_LT && byte_i == xmt_pkg::CH_BANG) begin
            ph_nxt = PH_BANG;
            mf_nxt = pos_r;
          end else begin
            // Tag name byte: ends at whitespace or '>', trailing slash trimmed
            mf_nxt = nm_mf;
            sf_nxt = (ph_r == PH_LT) ? 1'b0 : sf_r;
            ph_nxt = PH_NAME;
            if (byte_i == xmt_pkg::CH_GT || is_ws) begin
              if (pos_r != nm_mf && prev_r[7:0] == xmt_pkg::CH_SLASH) begin
                sf_nxt = 1'b1;
                nm_end = pos_r - OB'(1);
              end
              if (byte_i == xmt_pkg::CH_GT) begin
                emit   = 1'b1;
                kind   = xmt_pkg::TK_OPEN;
                sb     = nm_mf;
                se     = nm_end;
                sc     = sf_nxt;
                ph_nxt = PH_TEXT;
                mf_nxt = pos1;
                tf_nxt = TF_RESET;
              end else begin
                ms_nxt = nm_end;
                ph_nxt = PH_GAP;
              end
            end
          end
        end
        PH_CLOSE, PH_DECL: begin
          if (byte_i == xmt_pkg::CH_GT) begin
            emit   = 1'b1;
            kind   = (ph_r == PH_CLOSE) ? xmt_pkg::TK_CLOSE : xmt_pkg::TK_DECL;
            sb     = mf_r;
            se     = pos_r;
            ph_nxt = PH_TEXT;
            mf_nxt = pos1;
            tf_nxt = TF_RESET;
          end
        end
        PH_BANG, PH_COMMENT: begin
          if (ph_r == PH_BANG && byte_i == xmt_pkg::CH_LBRACK) begin
            cnt_nxt = CNT_W'(xmt_pkg::CDATA_SKIP);
            ph_nxt  = PH_CSKIP;
          end else begin
            // Track angle bracket nesting, saturating at the limit
            ph_nxt  = PH_COMMENT;
            cnt_nxt = cnt_in;
            if (byte_i == xmt_pkg::CH_GT) begin
              cnt_nxt = cnt_dec;
              if (cnt_dec == '0) begin
                emit   = 1'b1;
                kind   = xmt_pkg::TK_COMMENT;
                sb     = cl_b;
                se     = cl_e;
                ph_nxt = PH_TEXT;
                mf_nxt = pos1;
                tf_nxt = TF_RESET;
              end
            end else if (byte_i == xmt_pkg::CH_LT) begin
              if (cnt_in < CNT_W'(NEST_LIMIT)) begin
                cnt_nxt = cnt_in + CNT_W'(1);
              end
            end
          end
        end
        PH_CSKIP: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            ph_nxt = PH_CBODY;
          end
        end
        PH_CBODY: begin
          if (byte_i == xmt_pkg::CH_GT &&
              prev_r == {xmt_pkg::CH_RBRACK, xmt_pkg::CH_RBRACK}) begin
            emit   = 1'b1;
            kind   = xmt_pkg::TK_CDATA;
            sb     = cl_b;
            se     = cl_e;
            ph_nxt = PH_TEXT;
            mf_nxt = pos1;
            tf_nxt = TF_RESET;
          end
        end
        PH_GAP: begin
          if (byte_i == xmt_pkg::CH_GT) begin
            emit   = 1'b1;
            kind   = xmt_pkg::TK_OPEN;
            sb     = mf_r;
            se     = ms_r;
            sc     = sf_r;
            ph_nxt = PH_TEXT;
            mf_nxt = pos1;
            tf_nxt = TF_RESET;
          end else if (is_ws) begin
            // Skip whitespace between attributes
          end else if (byte_i == xmt_pkg::CH_SLASH) begin
            sf_nxt = 1'b1;
            ph_nxt = PH_SLASH;
          end else begin
            mt_nxt = pos_r;
            ph_nxt = PH_ANAME;
            if (byte_i == xmt_pkg::CH_EQ) begin
              m4_nxt = pos_r;
              ph_nxt = PH_SEEKQ;
            end
          end
        end
        PH_ANAME: begin
          if (is_ws || byte_i == xmt_pkg::CH_EQ) begin
            m4_nxt = pos_r;
            ph_nxt = PH_SEEKQ;
          end
        end
        PH_SEEKQ: begin
          if (byte_i == xmt_pkg::CH_DQ || byte_i == xmt_pkg::CH_SQ) begin
            quote_nxt = byte_i;
            m5_nxt    = pos1;
            ph_nxt    = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (byte_i == quote_r) begin
            emit   = 1'b1;
            kind   = xmt_pkg::TK_ATTR;
            sb     = mt_r;
            se     = m4_r;
            vb     = m5_r;
            ve     = pos_r;
            ph_nxt = PH_GAP;
          end
        end
        PH_SLASH: begin
          // Byte after a separate slash closes the tag, whatever it is
          emit   = 1'b1;
          kind   = xmt_pkg::TK_OPEN;
          sb     = mf_r;
          se     = ms_r;
          sc     = 1'b1;
          ph_nxt = PH_TEXT;
          mf_nxt = pos1;
          tf_nxt = TF_RESET;
        end
        default: begin
        end
      endcase

      prev_nxt = {prev_r[7:0], byte_i};
      pos_nxt  = pos1;

      // Last byte of the buffer: close out, flag an unfinished construct
      if (fin_i) begin
        if (!emit && ph_nxt != PH_TEXT) begin
          emit = 1'b1;
          kind = xmt_pkg::TK_MALFORMED;
          sb   = mf_nxt;
          se   = pos1;
          vb   = '0;
          ve   = '0;
          sc   = 1'b0;
        end
        ph_nxt = PH_DONE;
      end
    end
  end

  // Advance the scan state once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_TEXT;
      pos_r   <= '0;
      mf_r    <= '0;
      ms_r    <= '0;
      mt_r    <= '0;
      m4_r    <= '0;
      m5_r    <= '0;
      quote_r <= '0;
      cnt_r   <= '0;
      prev_r  <= '0;
      tf_r    <= TF_RESET;
      sf_r    <= 1'b0;
    end else if (step_i) begin
      ph_r    <= ph_nxt;
      pos_r   <= pos_nxt;
      mf_r    <= mf_nxt;
      ms_r    <= ms_nxt;
      mt_r    <= mt_nxt;
      m4_r    <= m4_nxt;
      m5_r    <= m5_nxt;
      quote_r <= quote_nxt;
      cnt_r   <= cnt_nxt;
      prev_r  <= prev_nxt;
      tf_r    <= tf_nxt;
      sf_r    <= sf_nxt;
    end
  end

  assign emit_o             = emit;
  assign tok_o.kind         = kind;
  assign tok_o.span_begin   = to_fld(sb);
  assign tok_o.span_end     = to_fld(se);
  assign tok_o.value_begin  = to_fld(vb);
  assign tok_o.value_end    = to_fld(ve);
  assign tok_o.self_closing = sc;

endmodule

`default_nettype wire

FILE: rtl/xmt_out_stage.sv
// Output register of the tokenizer: holds one token record until the sink takes it.
// Depends on xmt_pkg for the record type.
`default_nettype none

module xmt_out_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load_i,
  input  wire xmt_pkg::token_t tok_i,
  output logic                 can_load_o,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output xmt_pkg::token_t      tok_o
);

  logic            vld_r;
  xmt_pkg::token_t tok_r;

  // Free when empty or when the held record leaves this cycle
  assign can_load_o = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (can_load_o) begin
      vld_r <= load_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i && can_load_o) begin
      tok_r <= tok_i;
    end
  end

  assign out_valid = vld_r;
  assign tok_o     = tok_r;

endmodule

`default_nettype wire

FILE: rtl/xml_markup_tokenizer.sv
// Top level of the XML markup tokenizer: input register, scan state machine, output register.
// Depends on xmt_pkg, xmt_if, xmt_in_stage, xmt_scan and xmt_out_stage.
//
// Usage:
//   in_bus carries one document byte per beat (data_byte) and a last-byte flag
//   (final_byte). A zero byte or a final byte ends the document; later bytes are
//   taken and dropped until reset.
//   out_bus carries token records: kind, name or text span, attribute value span
//   and the self-closing flag. Each byte yields at most one record.
//   A record's byte is scanned from the input register, and the record is loaded
//   into the output register, which drives out_bus.
//   Throughput: one byte per cycle while no record is held back, set by the scan
//   state loop (phase, offset, marks), which updates on every consumed byte.
//   Stall: while a record waits on out_bus, bytes that make no record still flow;
//   a byte that would make one waits in the input register and in_bus.ready
//   drops once that register is full.
//   Reset (rst_n low, synchronous) clears both registers and returns the scanner
//   to the text phase at offset zero.
`default_nettype none

module xml_markup_tokenizer #(
  parameter int OFFSET_BITS = 24,
  parameter int NEST_LIMIT  = 255
) (
  input wire logic  clk,
  input wire logic  rst_n,
  xmt_in_if.sink    in_bus,
  xmt_out_if.source out_bus
);

  logic            in_vld;
  logic [7:0]      in_byte;
  logic            in_fin;
  logic            emit;
  logic            out_can;
  logic            step;
  xmt_pkg::token_t tok;
  xmt_pkg::token_t out_tok;

  // Consume the held byte unless its record has nowhere to go
  assign step = in_vld && (!emit || out_can);

  xmt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_byte  (in_bus.data_byte),
    .in_final (in_bus.final_byte),
    .take_i   (step),
    .vld_o    (in_vld),
    .byte_o   (in_byte),
    .fin_o    (in_fin)
  );

  xmt_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .NEST_LIMIT  (NEST_LIMIT)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (in_byte),
    .fin_i  (in_fin),
    .emit_o (emit),
    .tok_o  (tok)
  );

  xmt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (step && emit),
    .tok_i      (tok),
    .can_load_o (out_can),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .tok_o      (out_tok)
  );

  assign out_bus.token_kind   = out_tok.kind;
  assign out_bus.span_begin   = out_tok.span_begin;
  assign out_bus.span_end     = out_tok.span_end;
  assign out_bus.value_begin  = out_tok.value_begin;
  assign out_bus.value_end    = out_tok.value_end;
  assign out_bus.self_closing = out_tok.self_closing;

endmodule

`default_nettype wire

FILE: rtl/xmt_checker.sv
// Port-level checker of the tokenizer and its bind to the top level.
// Depends on xmt_pkg and the assertion macros header.
`default_nettype none
`include "xml_markup_tokenizer_assert.svh"

module xmt_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [2:0]                 token_kind,
  input wire logic [xmt_pkg::SPAN_W-1:0] span_begin,
  input wire logic [xmt_pkg::SPAN_W-1:0] span_end,
  input wire logic [xmt_pkg::SPAN_W-1:0] value_begin,
  input wire logic [xmt_pkg::SPAN_W-1:0] value_end,
  input wire logic                       self_closing
);

  logic is_attr;
  logic is_open;

  assign is_attr = (token_kind == xmt_pkg::TK_ATTR);
  assign is_open = (token_kind == xmt_pkg::TK_OPEN);

  // Hold a stalled record
  `XMT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(span_begin) && $stable(span_end) && $stable(value_begin) && $stable(value_end) && $stable(self_closing), "stalled token record changed")

  // Only attribute records carry a value span
  `XMT_ASSERT_NOW(a_value_zero, clk, rst_n, out_valid && !is_attr, value_begin == '0 && value_end == '0, "value span on a non-attribute record")

  // Only opening tags close themselves
  `XMT_ASSERT_NOW(a_self_open, clk, rst_n, out_valid && self_closing, is_open, "self-closing flag on a record other than an opening tag")

  // Drop the output after reset
  `XMT_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, !out_valid, "token output valid right after reset")

endmodule

bind xml_markup_tokenizer xmt_checker u_xmt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .token_kind   (out_bus.token_kind),
  .span_begin   (out_bus.span_begin),
  .span_end     (out_bus.span_end),
  .value_begin  (out_bus.value_begin),
  .value_end    (out_bus.value_end),
  .self_closing (out_bus.self_closing)
);

`default_nettype wire

FILE: dv/tb_xml_markup_tokenizer.sv
// Testbench for xml_markup_tokenizer: streams one document byte per beat and
// checks every token record against an in-bench scan model or typed row.
// Depends on xmt_pkg, xmt_if and the xml_markup_tokenizer RTL.
`default_nettype none

module tb_xml_markup_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import xmt_pkg::*;

  localparam int NEST_MAX = 255;
  localparam int DOC_TARGET = 1420;

  // One stimulus beat, with an optional hand-written expected record
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    token_t     tok;
  } byte_row_t;

  typedef enum logic [3:0] {
    ST_TEXT, ST_LT, ST_CLOSE, ST_DECL, ST_BANG, ST_CSKIP, ST_CBODY, ST_COMMENT,
    ST_NAME, ST_GAP, ST_ANAME, ST_SEEKQ, ST_VALUE, ST_SLASH, ST_DONE
  } scan_phase_e;

  // Short document: trailing-slash tag, short blank run, decl, 0xFF text,
  // empty close tag, inverted comment span, attribute and separate slash
  localparam byte_row_t DIRECTED_ROWS [26] = '{
    '{CH_LT,     1'b0, 1'b0, '0},
    '{"a",       1'b0, 1'b0, '0},
    '{CH_SLASH,  1'b0, 1'b0, '0},
    '{CH_GT,     1'b0, 1'b1, '{TK_OPEN, 24'd1, 24'd2, 24'd0, 24'd0, 1'b1}},
    '{CH_SP,     1'b0, 1'b0, '0},
    '{CH_LF,     1'b0, 1'b0, '0},
    '{CH_LT,     1'b0, 1'b0, '0},
    '{CH_QMARK,  1'b0, 1'b0, '0},
    '{CH_GT,     1'b0, 1'b0, '0},
    '{8'hFF,     1'b0, 1'b0, '0},
    '{CH_LT,     1'b0, 1'b1, '{TK_TEXT, 24'd9, 24'd10, 24'd0, 24'd0, 1'b0}},
    '{CH_SLASH,  1'b0, 1'b0, '0},
    '{CH_GT,     1'b0, 1'b0, '0},
    '{CH_LT,     1'b0, 1'b0, '0},
    '{CH_BANG,   1'b0, 1'b0, '0},
    '{CH_GT,     1'b0, 1'b1, '{TK_COMMENT, 24'd17, 24'd17, 24'd0, 24'd0, 1'b0}},
    '{CH_LT,     1'b0, 1'b0, '0},
    '{"b",       1'b0, 1'b0, '0},
    '{CH_TAB,    1'b0, 1'b0, '0},
    '{"c",       1'b0, 1'b0, '0},
    '{CH_EQ,     1'b0, 1'b0, '0},
    '{CH_SQ,     1'b0, 1'b0, '0},
    '{8'h80,     1'b0, 1'b0, '0},
    '{CH_SQ,     1'b0, 1'b0, '0},
    '{CH_SLASH,  1'b0, 1'b0, '0},
    '{CH_GT,     1'b0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  xmt_in_if  in_ch ();
  xmt_out_if out_ch ();

  xml_markup_tokenizer #(
    .OFFSET_BITS(SPAN_W),
    .NEST_LIMIT (NEST_MAX)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scan model state
  scan_phase_e       sc_phase;
  logic [SPAN_W-1:0] sc_pos;
  logic [SPAN_W-1:0] sc_mark1, sc_mark2, sc_mark3, sc_mark4, sc_mark5;
  logic [7:0]        sc_quote;
  int                sc_count;
  logic [15:0]       sc_prev2;
  logic [2:0]        sc_text;
  bit                sc_self;

  token_t      pending_tokens [$];
  byte_row_t   doc_rows [$];
  int          failures;
  int          records_checked;
  int          bytes_sent;
  int          burst_left;
  bit          draining;
  logic [7:0]  kinds_seen;
  int unsigned ready_cycle;

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic token_t make_token(input token_kind_t k,
                                        input logic [SPAN_W-1:0] sb, se, vb, ve,
                                        input logic sc);
    token_t t;
    t.kind = k;
    t.span_begin = sb;
    t.span_end = se;
    t.value_begin = vb;
    t.value_end = ve;
    t.self_closing = sc;
    return t;
  endfunction

  // Collapse an inverted span to empty at its begin
  function automatic token_t span_token(input token_kind_t k,
                                        input logic [SPAN_W-1:0] b, e);
    return make_token(k, b, (e < b) ? b : e, '0, '0, 1'b0);
  endfunction

  function automatic void enter_text(input logic [SPAN_W-1:0] p);
    sc_phase = ST_TEXT;
    sc_mark1 = p + 1'b1;
    sc_text = 3'b100;
  endfunction

  // Tag name ends at whitespace or '>'; a trailing slash marks self-closing
  function automatic bit name_end(input logic [7:0] c, input logic [SPAN_W-1:0] p,
                                  output token_t tok);
    logic [SPAN_W-1:0] e;
    tok = '0;
    if (c == CH_GT || is_space(c)) begin
      e = p;
      if (e != sc_mark1 && sc_prev2[7:0] == CH_SLASH) begin
        sc_self = 1'b1;
        e = p - 1'b1;
      end
      if (c == CH_GT) begin
        tok = make_token(TK_OPEN, sc_mark1, e, '0, '0, sc_self);
        enter_text(p);
        return 1'b1;
      end
      sc_mark2 = e;
      sc_phase = ST_GAP;
    end
    return 1'b0;
  endfunction

  // Track nested angle brackets; close the comment on the balancing '>'
  function automatic bit comment_end(input logic [7:0] c, input logic [SPAN_W-1:0] p,
                                     output token_t tok);
    logic [SPAN_W-1:0] b, e;
    tok = '0;
    if (c == CH_GT) begin
      if (sc_count > 0) sc_count--;
      if (sc_count == 0) begin
        b = sc_mark1 + SPAN_W'(COMMENT_LEAD);
        e = p - SPAN_W'(TAIL_TRIM);
        tok = span_token(TK_COMMENT, b, e);
        enter_text(p);
        return 1'b1;
      end
    end else if (c == CH_LT) begin
      if (sc_count < NEST_MAX) sc_count++;
    end
    return 1'b0;
  endfunction

  function automatic bit scan_byte(input logic [7:0] c, input logic [SPAN_W-1:0] p,
                                   output token_t tok);
    logic [2:0]        len;
    bit                made;
    logic [SPAN_W-1:0] b, e;
    tok = '0;
    case (sc_phase)
      ST_TEXT: begin
        len = {1'b0, sc_text[1:0]};
        if (c == CH_LT) begin
          made = len != 0 && !(len < 3 && sc_text[2]);
          if (made) tok = make_token(TK_TEXT, sc_mark1, p, '0, '0, 1'b0);
          sc_phase = ST_LT;
          sc_mark1 = p + 1'b1;
          return made;
        end
        if (len < 3) len++;
        sc_text = {sc_text[2] && is_space(c), len[1:0]};
      end
      ST_LT: begin
        sc_mark1 = p;
        if (c == CH_SLASH) begin
          sc_phase = ST_CLOSE;
          sc_mark1 = p + 1'b1;
        end else if (c == CH_QMARK) begin
          sc_phase = ST_DECL;
        end else if (c == CH_BANG) begin
          sc_phase = ST_BANG;
        end else begin
          sc_self = 1'b0;
          sc_phase = ST_NAME;
          return name_end(c, p, tok);
        end
      end
      ST_CLOSE, ST_DECL: begin
        if (c == CH_GT) begin
          tok = make_token((sc_phase == ST_CLOSE) ? TK_CLOSE : TK_DECL,
                           sc_mark1, p, '0, '0, 1'b0);
          enter_text(p);
          return 1'b1;
        end
      end
      ST_BANG: begin
        if (c == CH_LBRACK) begin
          sc_count = CDATA_SKIP;
          sc_phase = ST_CSKIP;
        end else begin
          sc_count = 1;
          sc_phase = ST_COMMENT;
          return comment_end(c, p, tok);
        end
      end
      ST_CSKIP: begin
        if (sc_count > 0) sc_count--;
        if (sc_count == 0) sc_phase = ST_CBODY;
      end
      ST_CBODY: begin
        if (c == CH_GT && sc_prev2 == {CH_RBRACK, CH_RBRACK}) begin
          b = sc_mark1 + SPAN_W'(CDATA_LEAD);
          e = p - SPAN_W'(TAIL_TRIM);
          tok = span_token(TK_CDATA, b, e);
          enter_text(p);
          return 1'b1;
        end
      end
      ST_COMMENT: return comment_end(c, p, tok);
      ST_NAME: return name_end(c, p, tok);
      ST_GAP: begin
        if (c == CH_GT) begin
          tok = make_token(TK_OPEN, sc_mark1, sc_mark2, '0, '0, sc_self);
          enter_text(p);
          return 1'b1;
        end
        if (c == CH_SLASH) begin
          sc_self = 1'b1;
          sc_phase = ST_SLASH;
        end else if (!is_space(c)) begin
          sc_mark3 = p;
          sc_phase = ST_ANAME;
          if (c == CH_EQ) begin
            sc_mark4 = p;
            sc_phase = ST_SEEKQ;
          end
        end
      end
      ST_ANAME: begin
        if (is_space(c) || c == CH_EQ) begin
          sc_mark4 = p;
          sc_phase = ST_SEEKQ;
        end
      end
      ST_SEEKQ: begin
        if (c == CH_DQ || c == CH_SQ) begin
          sc_quote = c;
          sc_mark5 = p + 1'b1;
          sc_phase = ST_VALUE;
        end
      end
      ST_VALUE: begin
        if (c == sc_quote) begin
          tok = make_token(TK_ATTR, sc_mark3, sc_mark4, sc_mark5, p, 1'b0);
          sc_phase = ST_GAP;
          return 1'b1;
        end
      end
      ST_SLASH: begin
        // Byte after a separate slash is swallowed and closes the tag
        tok = make_token(TK_OPEN, sc_mark1, sc_mark2, '0, '0, 1'b1);
        enter_text(p);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Advance the scan model by one byte; return 1 when a record is due
  function automatic bit tokenize_byte(input logic [7:0] c, input logic last,
                                       output token_t tok);
    logic [SPAN_W-1:0] p;
    bit                made;
    tok = '0;
    p = sc_pos;
    if (sc_phase == ST_DONE) return 1'b0;
    if (c == CH_NUL) begin
      made = sc_phase != ST_TEXT;
      if (made) tok = make_token(TK_MALFORMED, sc_mark1, p, '0, '0, 1'b0);
      sc_phase = ST_DONE;
      return made;
    end
    made = scan_byte(c, p, tok);
    sc_prev2 = {sc_prev2[7:0], c};
    sc_pos = p + 1'b1;
    if (last) begin
      if (!made && sc_phase != ST_TEXT) begin
        tok = make_token(TK_MALFORMED, sc_mark1, sc_pos, '0, '0, 1'b0);
        made = 1'b1;
      end
      sc_phase = ST_DONE;
    end
    return made;
  endfunction

  task automatic report_mismatch(input string what, input logic [SPAN_W-1:0] got,
                                 input logic [SPAN_W-1:0] want);
    failures++;
    if (failures <= 40)
      $display("%0t ns: record %0d %s: got %0h, expected %0h",
               $realtime, records_checked, what, got, want);
  endtask

  // Compare one accepted record with the oldest expectation
  task automatic check_record();
    token_t want;
    if (pending_tokens.size() == 0) begin
      report_mismatch("arrived with none expected, kind", SPAN_W'(out_ch.token_kind), '0);
      return;
    end
    want = pending_tokens.pop_front();
    if (out_ch.token_kind !== want.kind)
      report_mismatch("token_kind", SPAN_W'(out_ch.token_kind), SPAN_W'(want.kind));
    if (out_ch.span_begin !== want.span_begin)
      report_mismatch("span_begin", out_ch.span_begin, want.span_begin);
    if (out_ch.span_end !== want.span_end)
      report_mismatch("span_end", out_ch.span_end, want.span_end);
    if (out_ch.value_begin !== want.value_begin)
      report_mismatch("value_begin", out_ch.value_begin, want.value_begin);
    if (out_ch.value_end !== want.value_end)
      report_mismatch("value_end", out_ch.value_end, want.value_end);
    if (out_ch.self_closing !== want.self_closing)
      report_mismatch("self_closing", SPAN_W'(out_ch.self_closing),
                      SPAN_W'(want.self_closing));
    kinds_seen[want.kind] = 1'b1;
    records_checked++;
  endtask

  // Sample result beats; stall the receiver on a rotating pattern
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_record();
    ready_cycle <= ready_cycle + 1;
    if (draining) begin
      out_ch.ready <= 1'b1;
    end else begin
      case (ready_cycle[9:8])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= (ready_cycle % 7) != 3;
        2'd2: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ready_cycle[4:0] > 5'd11;
      endcase
    end
  end

  // Drive one byte beat in bursts with random gaps; predict on acceptance
  task automatic send_byte(input byte_row_t row);
    token_t predicted;
    bit     made;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 16);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= row.data;
    in_ch.final_byte <= row.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    made = tokenize_byte(row.data, row.last, predicted);
    if (row.typed) pending_tokens.push_back(row.tok);
    else if (made) pending_tokens.push_back(predicted);
  endtask

  // Hold the sender until every expected record has come out
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last = 1'b0);
    byte_row_t row;
    row = '0;
    row.data = b;
    row.last = last;
    doc_rows.push_back(row);
  endtask

  task automatic add_letters(input int n);
    repeat (n) add_byte(8'($urandom_range(97, 122)));
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_any();
    return 8'($urandom_range(1, 255));
  endfunction

  initial begin
    #2_000_000;
    $display("FAIL xml_markup_tokenizer");
    $finish;
  end

  initial begin
    logic [7:0] q, v;
    int         choice;
    bit         end_by_zero;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready = 1'b0;
    sc_phase = ST_TEXT;
    sc_pos = '0;
    sc_mark1 = '0;
    sc_mark2 = '0;
    sc_mark3 = '0;
    sc_mark4 = '0;
    sc_mark5 = '0;
    sc_quote = '0;
    sc_count = 0;
    sc_prev2 = '0;
    sc_text = 3'b100;
    sc_self = 1'b0;
    kinds_seen = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 26; i++) send_byte(DIRECTED_ROWS[i]);
    hold_until_drained();

    // Comment nested deep enough to saturate the bracket count
    add_byte(CH_LT);
    add_byte(CH_BANG);
    repeat (257) add_byte(CH_LT);
    add_byte("x");
    repeat (256) add_byte(CH_GT);

    // Mostly well-formed markup with random content, plus noise and breaks
    while (doc_rows.size() < DOC_TARGET) begin
      choice = $urandom_range(0, 99);
      if (choice < 18) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) add_byte(pick_space());
        end else begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 2))
              0: add_byte(pick_space());
              1: add_letters(1);
              default: begin
                v = pick_any();
                add_byte((v == CH_LT) ? 8'h7E : v);
              end
            endcase
          end
        end
      end else if (choice < 46) begin
        add_byte(CH_LT);
        add_letters($urandom_range(1, 4));
        repeat ($urandom_range(0, 3)) begin
          add_byte(pick_space());
          if ($urandom_range(0, 5) == 0) add_byte(pick_space());
          add_letters($urandom_range(1, 3));
          add_byte(($urandom_range(0, 3) == 0) ? pick_space() : CH_EQ);
          if ($urandom_range(0, 4) == 0) add_byte(pick_space());
          q = ($urandom_range(0, 1) == 0) ? CH_DQ : CH_SQ;
          add_byte(q);
          repeat ($urandom_range(0, 5)) begin
            do v = pick_any(); while (v == q);
            add_byte(v);
          end
          add_byte(q);
        end
        case ($urandom_range(0, 4))
          0: add_byte(CH_GT);
          1: begin
            add_byte(CH_SLASH);
            add_byte(CH_GT);
          end
          2: begin
            add_byte(pick_space());
            add_byte(CH_SLASH);
            add_byte(CH_GT);
          end
          3: begin
            add_byte(pick_space());
            add_byte(CH_GT);
          end
          default: begin
            add_byte(CH_SLASH);
            add_byte(pick_space());
            add_byte(CH_SLASH);
            add_byte(pick_any());
          end
        endcase
      end else if (choice < 58) begin
        add_byte(CH_LT);
        add_byte(CH_SLASH);
        add_letters($urandom_range(0, 4));
        add_byte(CH_GT);
      end else if (choice < 66) begin
        add_byte(CH_LT);
        add_byte(CH_BANG);
        add_byte(CH_LBRACK);
        add_byte("C");
        add_byte("D");
        add_byte("A");
        add_byte("T");
        add_byte("A");
        add_byte(CH_LBRACK);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 5))
            0: add_byte(CH_RBRACK);
            1: add_byte(CH_GT);
            default: add_letters(1);
          endcase
        end
        add_byte(CH_RBRACK);
        add_byte(CH_RBRACK);
        add_byte(CH_GT);
      end else if (choice < 76) begin
        add_byte(CH_LT);
        add_byte(CH_BANG);
        if ($urandom_range(0, 2) != 0) begin
          add_byte("-");
          add_byte("-");
          repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 4))
              0: begin
                add_byte(CH_LT);
                add_letters(1);
                add_byte(CH_GT);
              end
              1: add_byte("-");
              2: add_byte(pick_space());
              default: add_letters(1);
            endcase
          end
          add_byte("-");
          add_byte("-");
        end else begin
          add_letters(3);
          add_byte(CH_SP);
          add_letters(2);
        end
        add_byte(CH_GT);
      end else if (choice < 84) begin
        add_byte(CH_LT);
        add_byte(CH_QMARK);
        add_letters($urandom_range(1, 3));
        add_byte(CH_SP);
        add_letters($urandom_range(0, 4));
        add_byte(CH_QMARK);
        add_byte(CH_GT);
      end else if (choice < 92) begin
        add_byte(CH_LT);
        repeat ($urandom_range(1, 3)) add_byte(pick_any());
      end else begin
        repeat ($urandom_range(1, 4)) add_byte(pick_any());
      end
    end

    // End the document, sometimes inside an unfinished construct
    choice = $urandom_range(0, 3);
    if (choice[0]) begin
      case ($urandom_range(0, 2))
        0: begin
          add_byte(CH_LT);
          add_letters(2);
        end
        1: begin
          add_byte(CH_LT);
          add_byte(CH_BANG);
          add_byte("-");
          add_letters(2);
        end
        default: begin
          add_byte(CH_LT);
          add_letters(1);
          add_byte(CH_SP);
          add_letters(1);
          add_byte(CH_EQ);
          add_byte(CH_DQ);
          add_letters(1);
        end
      endcase
    end
    end_by_zero = choice[1];
    if (end_by_zero) add_byte(CH_NUL);
    else doc_rows[doc_rows.size() - 1].last = 1'b1;

    // Bytes after the end must be dropped
    add_byte(CH_NUL);
    add_byte(pick_any(), 1'b1);
    add_byte(CH_NUL, 1'b1);
    add_byte(8'hFF);

    foreach (doc_rows[i]) begin
      if (i > 0 && i % 350 == 0) hold_until_drained();
      send_byte(doc_rows[i]);
    end
    hold_until_drained();
    draining = 1'b1;
    repeat (16) @(posedge clk);

    $display("Streamed %0d bytes (26 directed), checked %0d token records, kinds seen %b",
             bytes_sent, records_checked, kinds_seen);
    $display("Document closed by %s", end_by_zero ? "a zero byte" : "the last-byte flag");
    if (failures == 0) begin
      $display("PASS xml_markup_tokenizer");
    end else begin
      $display("FAIL xml_markup_tokenizer");
    end
    $finish;
  end

endmodule

`default_nettype wire
